// ===== src/assert_macros.svh =====
// Assertion macros shared by the RTL of the ordered list engine.
// Each macro expands to a clocked concurrent assertion, or to nothing in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every rising edge outside reset
`define OLA_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
// Expression must never be true outside reset
`define OLA_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");
`else
`define OLA_ASSERT(label, clk, rst_n, prop)
`define OLA_NEVER(label, clk, rst_n, expr)
`endif
`endif

// ===== src/ola_pkg.sv =====
// Types and request codes for the ordered list engine.
// No dependencies; imported by the top level.
`timescale 1ns / 1ps
`default_nettype none

package ola_pkg;

    // Request codes
    localparam logic [2:0] REQ_APPEND = 3'd0;
    localparam logic [2:0] REQ_INSERT = 3'd1;
    localparam logic [2:0] REQ_CLEAR  = 3'd2;
    localparam logic [2:0] REQ_SEARCH = 3'd3;
    localparam logic [2:0] REQ_DELETE = 3'd4;

    typedef struct packed {
        logic [2:0]         req_type;
        logic [3:0]         position;
        logic signed [31:0] value;
    } req_t;

    typedef struct packed {
        logic       ok;
        logic       found;
        logic [3:0] found_index;
        logic [4:0] count;
    } rsp_t;

endpackage

`default_nettype wire

// ===== src/ola_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module ola_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== src/ordered_array_list_engine_core.sv =====
// Ordered list engine: append, insert, delete, search and clear on up to CAPACITY
// signed words in one ola_ram (registered read); types and codes from ola_pkg.
// Append, clear and rejected requests go straight to the result beat; insert,
// delete and search first walk the RAM, moving or comparing the entries concerned
// one a cycle. A new request is taken only after the last result beat is taken.
// Reset empties the list (count 0); stored words are not cleared.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ordered_array_list_engine_core
    import ola_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_stall,
    input  wire req_t req_data,
    output logic      rsp_valid,
    input  wire logic rsp_stall,
    output rsp_t      rsp_data
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > 4) ? CW : 4;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_RESP = 2'd2;

    logic [1:0]         state_reg, state_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic [2:0]         op_reg, op_next;
    logic [IW-1:0]      pos_reg, pos_next;
    logic signed [31:0] val_reg, val_next;
    logic [IW-1:0]      cur_reg, cur_next;
    logic [CW-1:0]      rem_reg, rem_next;
    logic               pend_reg, pend_next;
    logic [IW-1:0]      pend_addr_reg, pend_addr_next;
    logic               hit_reg, hit_next;
    logic [IW-1:0]      hit_idx_reg, hit_idx_next;
    rsp_t               rsp_reg, rsp_next;

    logic               mem_we;
    logic [IW-1:0]      mem_waddr;
    logic [31:0]        mem_wdata;
    logic [IW-1:0]      mem_raddr;
    logic [31:0]        mem_rdata;

    logic               accept;
    logic               full;
    logic               pos_ok;

    ola_ram #(
        .WIDTH (32),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = (state_reg == S_RESP);
    assign rsp_data  = rsp_reg;
    assign accept    = req_valid && !req_stall;
    assign full      = (cnt_reg == CW'(CAPACITY));
    assign pos_ok    = (PW'(req_data.position) < PW'(cnt_reg));

    // Sequencer: decode request, walk the RAM one entry a cycle, finish
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        op_next        = op_reg;
        pos_next       = pos_reg;
        val_next       = val_reg;
        cur_next       = cur_reg;
        rem_next       = rem_reg;
        pend_next      = 1'b0;
        pend_addr_next = pend_addr_reg;
        hit_next       = hit_reg;
        hit_idx_next   = hit_idx_reg;
        rsp_next       = rsp_reg;
        mem_we         = 1'b0;
        mem_waddr      = cur_reg;
        mem_wdata      = val_reg;
        mem_raddr      = cur_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next      = req_data.req_type;
                    pos_next     = IW'(req_data.position);
                    val_next     = req_data.value;
                    hit_next     = 1'b0;
                    hit_idx_next = '0;
                    rsp_next     = '0;
                    state_next   = S_RESP;
                    unique case (req_data.req_type)
                        REQ_APPEND:
                        begin
                            if (!full)
                            begin
                                mem_we      = 1'b1;
                                mem_waddr   = IW'(cnt_reg);
                                mem_wdata   = req_data.value;
                                cnt_next    = cnt_reg + CW'(1);
                                rsp_next.ok = 1'b1;
                            end
                        end
                        REQ_INSERT:
                        begin
                            if (!full && pos_ok)
                            begin
                                cur_next   = IW'(cnt_reg - CW'(1));
                                rem_next   = cnt_reg - CW'(req_data.position);
                                state_next = S_RUN;
                            end
                        end
                        REQ_CLEAR:
                        begin
                            cnt_next    = '0;
                            rsp_next.ok = 1'b1;
                        end
                        REQ_SEARCH:
                        begin
                            cur_next   = '0;
                            rem_next   = cnt_reg;
                            state_next = S_RUN;
                        end
                        REQ_DELETE:
                        begin
                            if (pos_ok)
                            begin
                                cur_next   = IW'(req_data.position) + IW'(1);
                                rem_next   = cnt_reg - CW'(1) - CW'(req_data.position);
                                state_next = S_RUN;
                            end
                        end
                        default:
                        begin
                            rsp_next.ok = 1'b0;
                        end
                    endcase
                    rsp_next.count = 5'(cnt_next);
                end
            end

            S_RUN:
            begin
                // Issue the next read and advance the source index
                if (rem_reg != '0)
                begin
                    mem_raddr      = cur_reg;
                    pend_next      = 1'b1;
                    pend_addr_next = cur_reg;
                    rem_next       = rem_reg - CW'(1);
                    cur_next       = (op_reg == REQ_INSERT) ? cur_reg - IW'(1)
                                                            : cur_reg + IW'(1);
                end

                // Consume the word read last cycle
                if (pend_reg)
                begin
                    case (op_reg)
                        REQ_INSERT:
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = pend_addr_reg + IW'(1);
                            mem_wdata = mem_rdata;
                        end
                        REQ_DELETE:
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = pend_addr_reg - IW'(1);
                            mem_wdata = mem_rdata;
                        end
                        REQ_SEARCH:
                        begin
                            if (!hit_reg && (mem_rdata == val_reg))
                            begin
                                hit_next     = 1'b1;
                                hit_idx_next = pend_addr_reg;
                            end
                        end
                        default:
                        begin
                            mem_we = 1'b0;
                        end
                    endcase
                end

                // Finish: on insert drop the new word in place; update the count on insert or delete
                if ((rem_reg == '0) && !pend_reg)
                begin
                    if (op_reg == REQ_INSERT)
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = pos_reg;
                        mem_wdata = val_reg;
                        cnt_next  = cnt_reg + CW'(1);
                    end
                    else if (op_reg == REQ_DELETE)
                    begin
                        cnt_next = cnt_reg - CW'(1);
                    end
                    rsp_next.ok          = 1'b1;
                    rsp_next.found       = hit_reg;
                    rsp_next.found_index = 4'(hit_idx_reg);
                    rsp_next.count       = 5'(cnt_next);
                    state_next           = S_RESP;
                end
            end

            S_RESP:
            begin
                // Hold the result beat until taken
                if (!rsp_stall)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            rem_reg   <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            rem_reg   <= rem_next;
            pend_reg  <= pend_next;
        end
    end

    // Payload and working registers
    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        pos_reg       <= pos_next;
        val_reg       <= val_next;
        cur_reg       <= cur_next;
        pend_addr_reg <= pend_addr_next;
        hit_reg       <= hit_next;
        hit_idx_reg   <= hit_idx_next;
        rsp_reg       <= rsp_next;
    end

    // Checks
    `OLA_ASSERT(a_cnt_bound, clk, rst_n, cnt_reg <= CW'(CAPACITY))
    `OLA_ASSERT(a_busy_after_accept, clk, rst_n, accept |=> req_stall)
    `OLA_ASSERT(a_cnt_hold_resp, clk, rst_n, (state_reg == S_RESP) |=> $stable(cnt_reg))
    `OLA_NEVER(a_no_write_resp, clk, rst_n, (state_reg == S_RESP) && mem_we)

endmodule

`default_nettype wire

// ===== tb/sv/ola_list_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the ordered list engine: watches both channels and keeps a
// shadow list. It predicts each result and compares it with the beat that comes
// back. Depends on ola_pkg for the beat types and request codes.
module ola_list_checker
    import ola_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    input  logic req_stall,
    input  req_t req_data,
    input  logic rsp_valid,
    input  logic rsp_stall,
    input  rsp_t rsp_data,
    output int   pending,
    output int   errors
);

    logic signed [31:0] shadow_words [DEPTH];
    int                 shadow_count;
    rsp_t               expected_rsp_q [$];
    rsp_t               want;

    initial
    begin
        shadow_count = 0;
        pending      = 0;
        errors       = 0;
    end

    // Apply one request to the shadow list and return the result it should give
    function automatic rsp_t apply_list_request(input req_t r);
        rsp_t res;
        int   i;
        res = '0;
        case (r.req_type)
            REQ_APPEND:
            begin
                if (shadow_count < DEPTH)
                begin
                    shadow_words[shadow_count] = r.value;
                    shadow_count++;
                    res.ok = 1'b1;
                end
            end
            REQ_INSERT:
            begin
                // position equal to count is rejected; append covers the end
                if (shadow_count < DEPTH && int'(r.position) < shadow_count)
                begin
                    for (i = shadow_count; i > int'(r.position); i--)
                        shadow_words[i] = shadow_words[i - 1];
                    shadow_words[r.position] = r.value;
                    shadow_count++;
                    res.ok = 1'b1;
                end
            end
            REQ_CLEAR:
            begin
                shadow_count = 0;
                res.ok       = 1'b1;
            end
            REQ_SEARCH:
            begin
                res.ok = 1'b1;
                // keep the lowest matching index
                for (i = 0; i < shadow_count; i++)
                begin
                    if (!res.found && shadow_words[i] == r.value)
                    begin
                        res.found       = 1'b1;
                        res.found_index = i[3:0];
                    end
                end
            end
            REQ_DELETE:
            begin
                if (int'(r.position) < shadow_count)
                begin
                    for (i = int'(r.position); i + 1 < shadow_count; i++)
                        shadow_words[i] = shadow_words[i + 1];
                    shadow_count--;
                    res.ok = 1'b1;
                end
            end
            default:
                ; // unused codes: rejected, list untouched
        endcase
        res.count = shadow_count[4:0];
        return res;
    endfunction

    // Compare each result beat with the oldest prediction, then queue new ones
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_rsp_q.size() == 0)
                begin
                    $display("%0t: result beat with no request waiting: ok=%0b found=%0b index=%0d count=%0d",
                             $time, rsp_data.ok, rsp_data.found, rsp_data.found_index,
                             rsp_data.count);
                    errors++;
                end
                else
                begin
                    want = expected_rsp_q.pop_front();
                    if (rsp_data !== want)
                    begin
                        $display("%0t: mismatch: expected ok=%0b found=%0b index=%0d count=%0d",
                                 $time, want.ok, want.found, want.found_index, want.count);
                        $display("%0t:           actual   ok=%0b found=%0b index=%0d count=%0d",
                                 $time, rsp_data.ok, rsp_data.found, rsp_data.found_index,
                                 rsp_data.count);
                        errors++;
                    end
                end
            end
            if (req_valid && !req_stall)
                expected_rsp_q.push_back(apply_list_request(req_data));
            pending = expected_rsp_q.size();
        end
    end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// Top of the ordered list engine testbench: clock, reset, request stimulus and
// result-side stalls. Needs ola_pkg, the engine core and ola_list_checker.
module tb;
    import ola_pkg::*;

    localparam int CLK_PERIOD    = 10;
    localparam int LIST_DEPTH    = 16;
    localparam int RANDOM_ITEMS  = 1750;
    localparam int CALM_TAIL     = 200;
    localparam int SEGMENT_LEN   = 40;
    localparam int SETTLE_CYCLES = 40;
    localparam int HISTORY_DEPTH = 32;

    localparam logic [2:0] REQ_SPARE_FIRST = 3'd5;
    localparam logic [2:0] REQ_SPARE_LAST  = 3'd7;

    localparam int MODE_GROW   = 0;
    localparam int MODE_SHRINK = 1;
    localparam int MODE_MIX    = 2;

    localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] WORD_MAX = 32'sh7fff_ffff;

    logic clk = 1'b0;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    req_t req_data;
    logic rsp_valid;
    logic rsp_stall;
    rsp_t rsp_data;
    int   fail_count;
    int   pending_count;

    // Idling is allowed only while this is set
    logic               idle_on = 1'b0;
    logic signed [31:0] sent_vals [$];

    ordered_array_list_engine_core #(
        .CAPACITY(LIST_DEPTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req_data (req_data),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp_data (rsp_data)
    );

    ola_list_checker #(
        .DEPTH(LIST_DEPTH)
    ) list_chk (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req_data (req_data),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp_data (rsp_data),
        .pending  (pending_count),
        .errors   (fail_count)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Hard stop in case the engine hangs
    initial
    begin
        #4_000_000;
        $display("tb NOT OK");
        $finish;
    end

    // Stall the result channel in random bursts while idle_on is set
    initial
    begin : rsp_side
        int stall_len;
        rsp_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (idle_on && $urandom_range(0, 4) == 0)
            begin
                stall_len = $urandom_range(1, 8);
                rsp_stall <= 1'b1;
                repeat (stall_len) @(negedge clk);
                rsp_stall <= 1'b0;
            end
        end
    end

    // Drive one request beat, with an optional gap ahead, and wait until taken
    task automatic send_req(input req_t r);
        int gap;
        @(negedge clk);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 8);
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= r;
        do
            @(posedge clk);
        while (req_stall);
    endtask

    task automatic issue(input logic [2:0] op, input logic [3:0] pos,
                         input logic signed [31:0] val);
        req_t r;
        r.req_type = op;
        r.position = pos;
        r.value    = val;
        send_req(r);
        // remember stored values so searches can hit
        if (op == REQ_APPEND || op == REQ_INSERT)
        begin
            sent_vals.push_back(val);
            if (sent_vals.size() > HISTORY_DEPTH)
                void'(sent_vals.pop_front());
        end
    endtask

    // Hold off the sender until every result has come back
    task automatic wait_drained();
        @(negedge clk);
        req_valid <= 1'b0;
        while (pending_count != 0) @(negedge clk);
    endtask

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return WORD_MIN;
            1:       return WORD_MAX;
            2:       return -1;
            3, 4, 5: return $urandom_range(0, 7);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic signed [31:0] pick_search_value();
        if (sent_vals.size() > 0 && $urandom_range(0, 1) == 0)
            return sent_vals[$urandom_range(0, sent_vals.size() - 1)];
        return pick_value();
    endfunction

    // Weighted request mix; grow fills the list, shrink drains it
    function automatic logic [2:0] pick_op(input int mode);
        int roll;
        int c_app;
        int c_ins;
        int c_srch;
        int c_del;
        int c_clr;
        roll = $urandom_range(0, 99);
        case (mode)
            MODE_GROW:
            begin
                c_app = 40; c_ins = 70; c_srch = 88; c_del = 96; c_clr = 98;
            end
            MODE_SHRINK:
            begin
                c_app = 12; c_ins = 22; c_srch = 45; c_del = 90; c_clr = 95;
            end
            default:
            begin
                c_app = 25; c_ins = 45; c_srch = 70; c_del = 90; c_clr = 96;
            end
        endcase
        if (roll < c_app)
            return REQ_APPEND;
        if (roll < c_ins)
            return REQ_INSERT;
        if (roll < c_srch)
            return REQ_SEARCH;
        if (roll < c_del)
            return REQ_DELETE;
        if (roll < c_clr)
            return REQ_CLEAR;
        return 3'($urandom_range(REQ_SPARE_LAST, REQ_SPARE_FIRST));
    endfunction

    initial
    begin : stimulus
        int               done_items;
        int               seg_no;
        int               mode;
        logic [2:0]       op;
        logic signed [31:0] val;

        rst_n     = 1'b0;
        req_valid = 1'b0;
        req_data  = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty list, field extremes, rejects, duplicates, unused codes
        issue(REQ_SEARCH, 4'd0, 0);
        issue(REQ_DELETE, 4'd0, 0);
        issue(REQ_INSERT, 4'd0, 9);
        issue(REQ_APPEND, 4'd15, WORD_MIN);
        issue(REQ_APPEND, 4'd0, WORD_MAX);
        issue(REQ_APPEND, 4'd0, 0);
        issue(REQ_APPEND, 4'd0, -1);
        issue(REQ_INSERT, 4'd0, 5);
        issue(REQ_INSERT, 4'd4, 32'sh5555_5555);
        issue(REQ_INSERT, 4'd6, 32'sh2aaa_aaaa);
        issue(REQ_APPEND, 4'd0, 5);
        issue(REQ_SEARCH, 4'd0, 5);
        issue(REQ_SEARCH, 4'd0, -1);
        issue(REQ_SEARCH, 4'd0, WORD_MAX);
        issue(REQ_SEARCH, 4'd0, 12345);
        issue(REQ_DELETE, 4'd15, 0);
        issue(REQ_DELETE, 4'd6, 0);
        issue(REQ_DELETE, 4'd0, 0);
        issue(REQ_SPARE_FIRST, 4'd15, -1);
        issue(REQ_SPARE_LAST, 4'd0, WORD_MIN);
        issue(REQ_CLEAR, 4'd0, 0);
        issue(REQ_CLEAR, 4'd15, -1);
        wait_drained();

        // Random: segments of one mix, some with idling and some without
        done_items = 0;
        seg_no     = 0;
        while (done_items < RANDOM_ITEMS)
        begin
            mode    = $urandom_range(MODE_GROW, MODE_MIX);
            idle_on = (done_items < RANDOM_ITEMS - CALM_TAIL) && ($urandom_range(0, 3) != 0);
            if (seg_no == 3 || $urandom_range(0, 5) == 0)
                wait_drained();
            repeat (SEGMENT_LEN)
            begin
                if (done_items >= RANDOM_ITEMS - CALM_TAIL)
                    idle_on = 1'b0;
                op  = pick_op(mode);
                val = (op == REQ_SEARCH) ? pick_search_value() : pick_value();
                issue(op, 4'($urandom_range(0, 15)), val);
                if (op <= REQ_DELETE)
                    done_items++;
            end
            seg_no++;
        end

        // Let the last results come back, then give the verdict
        idle_on = 1'b0;
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
